/* rtl/sond_pkg.sv */
// ----------------------------------------------------------------------------
// sond_pkg
// Types, codes and constants shared by the symmetric orientation distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sond_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ELEM_W    = 16;
   localparam int COL_W     = 3 * ELEM_W;
   localparam int OPND_W    = 33;
   localparam int ACC_W     = 64;

   // pi with 30 fraction bits
   localparam logic [33:0] PI_Q30 = 34'd3373259426;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_NEAREST  = 2'd1,
      OP_DISTANCE = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_LOAD  = 12'b0000_0000_0010,
      S_MQR   = 12'b0000_0000_0100,
      S_TRACE = 12'b0000_0000_1000,
      S_JQ    = 12'b0000_0001_0000,
      S_POST1 = 12'b0000_0010_0000,
      S_POST2 = 12'b0000_0100_0000,
      S_SQRT  = 12'b0000_1000_0000,
      S_HORN  = 12'b0001_0000_0000,
      S_SP    = 12'b0010_0000_0000,
      S_WAIT  = 12'b0100_0000_0000,
      S_OUT   = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      K_MQR   = 3'd0,
      K_TRACE = 3'd1,
      K_JQ    = 3'd2,
      K_HORN  = 3'd3,
      K_SP    = 3'd4
   } kind_type;

   // one multiply issued to the shared unit
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [1:0] x0;
      logic [1:0] x1;
      logic [1:0] x2;
      logic [2:0] hk;
      logic       first;
      logic       last;
   } ctrl_type;

   function automatic logic signed [ELEM_W-1:0] col_elem(input logic [COL_W-1:0] col,
                                                        input logic [1:0] row);
      logic signed [ELEM_W-1:0] e;
      unique case (row)
         2'd0:    e = $signed(col[15:0]);
         2'd1:    e = $signed(col[31:16]);
         2'd2:    e = $signed(col[47:32]);
         default: e = '0;
      endcase
      return e;
   endfunction

   // arccos polynomial coefficients, Q30
   function automatic logic signed [31:0] acos_coef(input logic [2:0] k);
      logic signed [31:0] c;
      unique case (k)
         3'd0: c = 32'sd1686629713;
         3'd1: c = -32'sd230423709;
         3'd2: c = 32'sd95540460;
         3'd3: c = -32'sd53874250;
         3'd4: c = 32'sd33169905;
         3'd5: c = -32'sd18348235;
         3'd6: c = 32'sd7161955;
         3'd7: c = -32'sd1355590;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/sond_ram.sv */
// ----------------------------------------------------------------------------
// sond_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sond_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 72,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/symmetric_orientation_nearest_distance_unit.sv */
// ----------------------------------------------------------------------------
// symmetric_orientation_nearest_distance_unit
// Nearest symmetric equivalent of an orientation and its rotation distance.
// ----------------------------------------------------------------------------
// Holds up to MAX_GROUP symmetry rotations in a RAM, loaded one entry per word.
// A query word brings Q and R; the unit forms Q*R^T, then for each of the first
// group_size entries J the trace of J*Q*R^T, keeps the largest (first index on
// ties), and returns J_best*Q, the index, the trace and arccos((trace-1)/2).
// All products go through one 33x33 multiplier, one product per cycle, and the
// square root is a bit-serial unit. One word is processed at a time; a new word
// is taken while the previous result still waits on the result channel.
`default_nettype none

module symmetric_orientation_nearest_distance_unit #(
   parameter int MAX_GROUP = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata: index[4:0], a_col0, a_col1, a_col2, b_col0, b_col1, b_col2
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [295:0] req_tdata,
   // req_tuser: operation[1:0]
   input  wire logic [1:0]   req_tuser,
   // rsp_tdata: res_col0, res_col1, res_col2, best_index[4:0], best_trace[16:0],
   // angle[15:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [183:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [4:0]   csr_data
);

   import sond_pkg::*;

   localparam int EW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int DEPTH = 3 * MAX_GROUP;
   localparam int AW    = $clog2(DEPTH);

   localparam logic signed [42:0] TC_LO = -43'sd4294967296;
   localparam logic signed [42:0] TC_HI = 43'sd12884901888;
   localparam logic signed [42:0] ONE32 = 43'sd4294967296;

   // sequencer
   state_type          state_ff, state_in, ret_ff, ret_in;
   logic [1:0]         wait_ff, wait_in;
   logic [1:0]         x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic [EW-1:0]      e_ff, e_in, last_ff, last_in;
   logic [2:0]         hk_ff, hk_in;
   logic [4:0]         idx_ff, idx_in;
   logic               zero_ff, zero_in;
   logic [4:0]         group_size_ff, group_size_in;

   // operands and intermediate results
   logic signed [ELEM_W-1:0] q_ff [3][3];
   logic signed [ELEM_W-1:0] q_in [3][3];
   logic signed [ELEM_W-1:0] r_ff [3][3];
   logic signed [ELEM_W-1:0] r_in [3][3];
   logic signed [OPND_W-1:0] mqr_ff [9];
   logic signed [OPND_W-1:0] mqr_in [9];
   logic signed [ELEM_W-1:0] res_ff [3][3];
   logic signed [ELEM_W-1:0] res_in [3][3];
   logic signed [51:0]       best_t_ff, best_t_in;
   logic [EW-1:0]            best_e_ff, best_e_in;
   logic signed [42:0]       t32_ff, t32_in;
   logic signed [16:0]       trace_ff, trace_in;
   logic                     neg_ff, neg_in;
   logic [30:0]              u_ff, u_in;
   logic [62:0]              sv_ff, sv_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic signed [OPND_W-1:0] p_ff, p_in;
   logic [31:0]              m_ff, m_in;

   // multiply pipeline
   ctrl_type                 ctrl0, ctrl1_ff, ctrl2_ff;
   logic [EW-1:0]            e1_ff, e2_ff;
   logic signed [OPND_W-1:0] opa, opb;
   logic signed [65:0]       mul_w;
   logic signed [ACC_W-1:0]  prod_ff, prod_in, acc_ff, acc_in;

   // result channel
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [181:0]             rsp_data_ff, rsp_data_in;

   // table memory
   logic                     ram_we;
   logic [AW-1:0]            ram_addr;
   logic [COL_W-1:0]         ram_wdata, ram_rdata;

   sond_ram #(
      .WIDTH (COL_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   assign group_size_in = (csr_valid && csr_ready) ? csr_data : group_size_ff;

   // shared multiplier, operand select per issued word
   always_comb begin
      opa = '0;
      opb = '0;
      unique case (ctrl1_ff.kind)
         K_MQR: begin
            opa = OPND_W'(q_ff[ctrl1_ff.x2][ctrl1_ff.x0]);
            opb = OPND_W'(r_ff[ctrl1_ff.x1][ctrl1_ff.x0]);
         end
         K_TRACE: begin
            opa = OPND_W'(col_elem(ram_rdata, ctrl1_ff.x0));
            opb = mqr_ff[4'(3 * int'(ctrl1_ff.x1) + int'(ctrl1_ff.x0))];
         end
         K_JQ: begin
            opa = OPND_W'(col_elem(ram_rdata, ctrl1_ff.x1));
            opb = OPND_W'(q_ff[ctrl1_ff.x0][ctrl1_ff.x2]);
         end
         K_HORN: begin
            opa = p_ff;
            opb = $signed({2'b00, u_ff});
         end
         K_SP: begin
            opa = $signed({2'b00, sres_ff[30:0]});
            opb = p_ff;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      mul_w   = opa * opb;
      prod_in = $signed(mul_w[ACC_W-1:0]);
   end

   always_comb begin
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] rnd;
      logic signed [51:0]      tval;
      logic [6:0]              n_w;
      logic signed [52:0]      bt_r;
      logic signed [25:0]      tr_full;
      logic signed [42:0]      tc;
      logic signed [35:0]      xv;
      logic [35:0]             mag;
      logic [33:0]             uw;
      logic [30:0]             dsq;
      logic [62:0]             trial;
      logic signed [34:0]      ang;
      logic signed [34:0]      ang_r;
      logic [15:0]             ang_o;

      state_in    = state_ff;
      ret_in      = ret_ff;
      wait_in     = wait_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      e_in        = e_ff;
      last_in     = last_ff;
      hk_in       = hk_ff;
      idx_in      = idx_ff;
      zero_in     = zero_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      mqr_in      = mqr_ff;
      res_in      = res_ff;
      best_t_in   = best_t_ff;
      best_e_in   = best_e_ff;
      t32_in      = t32_ff;
      trace_in    = trace_ff;
      neg_in      = neg_ff;
      u_in        = u_ff;
      sv_in       = sv_ff;
      sres_in     = sres_ff;
      sbit_in     = sbit_ff;
      p_in        = p_ff;
      m_in        = m_ff;
      acc_in      = acc_ff;
      ctrl0       = '0;
      ram_we      = 1'b0;
      ram_addr    = '0;
      ram_wdata   = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      n_w     = '0;
      bt_r    = '0;
      tr_full = '0;
      tc      = '0;
      xv      = '0;
      mag     = '0;
      uw      = '0;
      dsq     = '0;
      trial   = '0;
      ang     = '0;
      ang_r   = '0;
      ang_o   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               idx_in  = req_tdata[4:0];
               zero_in = 1'b0;
               x0_in   = '0;
               x1_in   = '0;
               x2_in   = '0;
               e_in    = '0;
               hk_in   = 3'd6;
               for (int a = 0; a < 3; a++) begin
                  for (int c = 0; c < 3; c++) begin
                     q_in[a][c] = col_elem(req_tdata[5 + 48*c +: 48], 2'(a));
                     r_in[a][c] = col_elem(req_tdata[149 + 48*c +: 48], 2'(a));
                  end
               end
               // zero means one entry, above the table size means all of it
               n_w = (group_size_ff == '0) ? 7'd1 : {2'b00, group_size_ff};
               if (n_w > 7'(MAX_GROUP)) begin
                  n_w = 7'(MAX_GROUP);
               end
               last_in = EW'(n_w - 7'd1);
               unique case (op_type'(req_tuser))
                  OP_LOAD:     state_in = S_LOAD;
                  OP_NEAREST,
                  OP_DISTANCE: state_in = S_MQR;
                  OP_NONE: begin
                     zero_in  = 1'b1;
                     state_in = S_OUT;
                  end
                  default:     state_in = S_OUT;
               endcase
            end
         end
         S_LOAD: begin
            ram_we    = (32'(idx_ff) < 32'(MAX_GROUP));
            ram_addr  = AW'(3 * int'(idx_ff) + int'(x0_ff));
            ram_wdata = {q_ff[2][x0_ff], q_ff[1][x0_ff], q_ff[0][x0_ff]};
            if (x0_ff == 2'd2) begin
               x0_in    = '0;
               zero_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               x0_in = x0_ff + 2'd1;
            end
         end
         S_MQR, S_JQ: begin
            ctrl0.valid = 1'b1;
            ctrl0.kind  = (state_ff == S_MQR) ? K_MQR : K_JQ;
            ctrl0.x0    = x0_ff;
            ctrl0.x1    = x1_ff;
            ctrl0.x2    = x2_ff;
            ctrl0.first = (x0_ff == 2'd0);
            ctrl0.last  = (x0_ff == 2'd2);
            ram_addr    = AW'(3 * int'(best_e_ff) + int'(x0_ff));
            if (x0_ff == 2'd2) begin
               x0_in = '0;
               if (x1_ff == 2'd2) begin
                  x1_in = '0;
                  if (x2_ff == 2'd2) begin
                     x2_in    = '0;
                     e_in     = '0;
                     wait_in  = 2'd2;
                     ret_in   = (state_ff == S_MQR) ? S_TRACE : S_POST1;
                     state_in = S_WAIT;
                  end else begin
                     x2_in = x2_ff + 2'd1;
                  end
               end else begin
                  x1_in = x1_ff + 2'd1;
               end
            end else begin
               x0_in = x0_ff + 2'd1;
            end
         end
         S_TRACE: begin
            ctrl0.valid = 1'b1;
            ctrl0.kind  = K_TRACE;
            ctrl0.x0    = x0_ff;
            ctrl0.x1    = x1_ff;
            ctrl0.first = (x0_ff == 2'd0) && (x1_ff == 2'd0);
            ctrl0.last  = (x0_ff == 2'd2) && (x1_ff == 2'd2);
            ram_addr    = AW'(3 * int'(e_ff) + int'(x1_ff));
            if (x0_ff == 2'd2) begin
               x0_in = '0;
               if (x1_ff == 2'd2) begin
                  x1_in = '0;
                  if (e_ff == last_ff) begin
                     e_in     = '0;
                     wait_in  = 2'd2;
                     ret_in   = S_JQ;
                     state_in = S_WAIT;
                  end else begin
                     e_in = e_ff + EW'(1);
                  end
               end else begin
                  x1_in = x1_ff + 2'd1;
               end
            end else begin
               x0_in = x0_ff + 2'd1;
            end
         end
         S_POST1: begin
            // trace down to 32 fraction bits
            bt_r     = 53'(best_t_ff) + 53'sd512;
            t32_in   = 43'(bt_r >>> 10);
            state_in = S_POST2;
         end
         S_POST2: begin
            tr_full = 26'((44'(t32_ff) + 44'sd131072) >>> 18);
            if (tr_full > 26'sd49152) begin
               trace_in = 17'sd49152;
            end else if (tr_full < -26'sd49152) begin
               trace_in = -17'sd49152;
            end else begin
               trace_in = 17'(tr_full);
            end
            tc = t32_ff;
            if (t32_ff < TC_LO) begin
               tc = TC_LO;
            end else if (t32_ff > TC_HI) begin
               tc = TC_HI;
            end
            xv     = 36'(tc - ONE32);
            neg_in = xv[35];
            mag    = xv[35] ? 36'(-xv) : 36'(xv);
            uw     = 34'((mag + 36'd4) >> 3);
            if (uw > 34'd1073741824) begin
               uw = 34'd1073741824;
            end
            u_in     = 31'(uw);
            dsq      = 31'd1073741824 - 31'(uw);
            sv_in    = {2'b00, dsq, 30'd0};
            sres_in  = '0;
            sbit_in  = {1'b1, 62'd0};
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // one result bit per cycle
            trial = sres_ff + sbit_ff;
            if (sv_ff >= trial) begin
               sv_in   = sv_ff - trial;
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               p_in     = OPND_W'(acos_coef(3'd7));
               state_in = S_HORN;
            end
         end
         S_HORN: begin
            ctrl0.valid = 1'b1;
            ctrl0.kind  = K_HORN;
            ctrl0.hk    = hk_ff;
            ctrl0.first = 1'b1;
            ctrl0.last  = 1'b1;
            wait_in     = 2'd2;
            state_in    = S_WAIT;
            if (hk_ff == 3'd0) begin
               ret_in = S_SP;
            end else begin
               hk_in  = hk_ff - 3'd1;
               ret_in = S_HORN;
            end
         end
         S_SP: begin
            ctrl0.valid = 1'b1;
            ctrl0.kind  = K_SP;
            ctrl0.first = 1'b1;
            ctrl0.last  = 1'b1;
            wait_in     = 2'd2;
            ret_in      = S_OUT;
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            // let the multiply pipeline drain
            wait_in = wait_ff - 2'd1;
            if (wait_ff == 2'd1) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            ang   = neg_ff ? (35'(PI_Q30) - 35'(m_ff)) : 35'(m_ff);
            ang_r = (ang + 35'sd32768) >>> 16;
            if (ang_r < 0) begin
               ang_o = '0;
            end else if (ang_r > 35'sd65535) begin
               ang_o = 16'hFFFF;
            end else begin
               ang_o = 16'(ang_r);
            end
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               if (zero_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {ang_o, trace_ff, 5'(best_e_ff),
                                 res_ff[2][2], res_ff[2][1], res_ff[2][0],
                                 res_ff[1][2], res_ff[1][1], res_ff[1][0],
                                 res_ff[0][2], res_ff[0][1], res_ff[0][0]};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // accumulate and retire at the end of the multiply pipeline
      sum  = (ctrl2_ff.first ? '0 : acc_ff) + prod_ff;
      rnd  = '0;
      tval = 52'(sum);
      if (ctrl2_ff.valid) begin
         acc_in = sum;
         unique case (ctrl2_ff.kind)
            K_MQR: begin
               if (ctrl2_ff.last) begin
                  mqr_in[4'(3 * int'(ctrl2_ff.x2) + int'(ctrl2_ff.x1))] = OPND_W'(sum);
               end
            end
            K_TRACE: begin
               // strictly greater only, so the first index wins ties
               if (ctrl2_ff.last && ((e2_ff == '0) || (tval > best_t_ff))) begin
                  best_t_in = tval;
                  best_e_in = e2_ff;
               end
            end
            K_JQ: begin
               if (ctrl2_ff.last) begin
                  rnd = (sum + 64'sd8192) >>> 14;
                  if (rnd > 64'sd32767) begin
                     res_in[ctrl2_ff.x2][ctrl2_ff.x1] = 16'sh7FFF;
                  end else if (rnd < -64'sd32768) begin
                     res_in[ctrl2_ff.x2][ctrl2_ff.x1] = -16'sd32768;
                  end else begin
                     res_in[ctrl2_ff.x2][ctrl2_ff.x1] = 16'(rnd);
                  end
               end
            end
            K_HORN: begin
               rnd  = (prod_ff + 64'sd536870912) >>> 30;
               p_in = OPND_W'(rnd) + OPND_W'(acos_coef(ctrl2_ff.hk));
            end
            K_SP: begin
               rnd  = (prod_ff + 64'sd536870912) >>> 30;
               m_in = (rnd < 0) ? '0 : 32'(rnd);
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         wait_ff       <= '0;
         x0_ff         <= '0;
         x1_ff         <= '0;
         x2_ff         <= '0;
         e_ff          <= '0;
         hk_ff         <= '0;
         group_size_ff <= 5'd1;
         ctrl1_ff      <= '0;
         ctrl2_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         wait_ff       <= wait_in;
         x0_ff         <= x0_in;
         x1_ff         <= x1_in;
         x2_ff         <= x2_in;
         e_ff          <= e_in;
         hk_ff         <= hk_in;
         group_size_ff <= group_size_in;
         ctrl1_ff      <= ctrl0;
         ctrl2_ff      <= ctrl1_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      zero_ff     <= zero_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      mqr_ff      <= mqr_in;
      res_ff      <= res_in;
      best_t_ff   <= best_t_in;
      best_e_ff   <= best_e_in;
      t32_ff      <= t32_in;
      trace_ff    <= trace_in;
      neg_ff      <= neg_in;
      u_ff        <= u_in;
      sv_ff       <= sv_in;
      sres_ff     <= sres_in;
      sbit_ff     <= sbit_in;
      p_ff        <= p_in;
      m_ff        <= m_in;
      e1_ff       <= e_ff;
      e2_ff       <= e1_ff;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
